FILE: src/lsb_mask_block_frame_encoder_macros.svh
// Assertion helpers shared by the encoder checks.
`ifndef LSB_MASK_BLOCK_FRAME_ENCODER_MACROS_SVH
`define LSB_MASK_BLOCK_FRAME_ENCODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LMBFE_ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define LMBFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lmbfe_pkg.sv
`timescale 1ns / 1ps

package lmbfe_pkg;

    // Command codes carried in the input tuser field
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_COMMIT = 2'd2;

    localparam int         NARROW_DATA   = 7;
    localparam int         MASK_W        = 7;
    localparam int         PRE_LEN       = 3;
    localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
    localparam logic [7:0] LSB_CLEAR     = 8'hFE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PRE,
        S_MASK,
        S_DATA
    } t_state;

    typedef enum logic [1:0] {
        SEL_PRE,
        SEL_MASK,
        SEL_DATA
    } t_out_sel;

    // Controller to datapath
    typedef struct packed {
        logic     byte_wr;
        logic     blk_clr;
        logic     mode_wr;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     out_ld;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full_on_wr;
        logic fill_zero;
        logic cnt_pre_last;
        logic cnt_data_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: src/lmbfe_ctrl.sv
`timescale 1ns / 1ps

module lmbfe_ctrl
    import lmbfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic [1:0] i_s_cmd,
    input  logic       i_cfg_valid,
    input  t_dp_sts    i_sts,
    output logic       o_s_ready,
    output logic       o_cfg_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_in_acc;
    logic   w_cfg_acc;

    // Take items and register writes only between transactions of output work
    assign o_s_ready   = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_s_valid;
    assign w_in_acc    = i_s_valid && o_s_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_s_cmd)
                        CMD_START:  n_state = S_PRE;
                        CMD_DATA:   n_state = i_sts.full_on_wr ? S_MASK : S_IDLE;
                        CMD_COMMIT: n_state = i_sts.fill_zero ? S_IDLE : S_MASK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_PRE: begin
                if (i_sts.out_free && i_sts.cnt_pre_last) n_state = S_IDLE;
            end
            S_MASK: begin
                if (i_sts.out_free) n_state = S_DATA;
            end
            S_DATA: begin
                if (i_sts.out_free && i_sts.cnt_data_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = SEL_PRE;
        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    o_cmd.mode_wr = 1'b1;
                    o_cmd.blk_clr = 1'b1;
                end
                if (w_in_acc) begin
                    case (i_s_cmd)
                        CMD_START: begin
                            o_cmd.blk_clr = 1'b1;
                            o_cmd.cnt_clr = 1'b1;
                        end
                        CMD_DATA: o_cmd.byte_wr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_PRE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_sel  = SEL_PRE;
                    o_cmd.out_last = i_sts.cnt_pre_last;
                    o_cmd.cnt_inc  = 1'b1;
                end
            end
            S_MASK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.out_sel = SEL_MASK;
                    o_cmd.cnt_clr = 1'b1;
                end
            end
            S_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_sel  = SEL_DATA;
                    o_cmd.out_last = i_sts.cnt_data_last;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.blk_clr  = i_sts.cnt_data_last;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: src/lmbfe_dp.sv
`timescale 1ns / 1ps

module lmbfe_dp
    import lmbfe_pkg::*;
#(
    parameter int BLOCK_DATA_MAX = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_data,
    input  logic       i_cfg_data,
    input  logic       i_m_ready,
    output t_dp_sts    o_sts,
    output logic       o_m_valid,
    output logic [7:0] o_m_byte,
    output logic       o_m_last
);

    localparam int CW = $clog2(BLOCK_DATA_MAX);
    localparam int FW = $clog2(BLOCK_DATA_MAX + 1);

    logic              r_mode;
    logic [FW-1:0]     r_fill;
    logic [MASK_W-1:0] r_mask;
    logic [7:0]        r_store [BLOCK_DATA_MAX];
    logic [CW-1:0]     r_cnt;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [FW-1:0]     w_lim;
    logic              w_restart;
    logic [FW-1:0]     w_pos;
    logic [FW-1:0]     w_shift;
    logic [FW-1:0]     w_fill_inc;
    logic [MASK_W-1:0] w_mask_base;
    logic [MASK_W-1:0] n_mask;
    logic              w_takes;
    logic [7:0]        w_byte_clr;
    logic [7:0]        w_rd_byte;
    logic [7:0]        n_out_byte;

    // Store the byte; in wide mode only even slots give the mask an LSB
    always_comb begin
        w_lim       = r_mode ? FW'(BLOCK_DATA_MAX) : FW'(NARROW_DATA);
        w_restart   = (r_fill >= w_lim);
        w_pos       = w_restart ? '0 : r_fill;
        w_mask_base = w_restart ? '0 : r_mask;
        w_takes     = !r_mode || !w_pos[0];
        w_shift     = r_mode ? (w_pos >> 1) : w_pos;
        for (int k = 0; k < MASK_W; k++) begin
            n_mask[k] = w_mask_base[k] | (w_takes & i_data[0] & (w_shift == FW'(k)));
        end
        w_byte_clr = w_takes ? (i_data & LSB_CLEAR) : i_data;
        w_fill_inc = w_pos + FW'(1);
    end

    // Status for the controller
    always_comb begin
        o_sts.full_on_wr    = (w_fill_inc >= w_lim);
        o_sts.fill_zero     = (r_fill == '0);
        o_sts.cnt_pre_last  = (r_cnt == CW'(PRE_LEN - 1));
        o_sts.cnt_data_last = (FW'(r_cnt) == (r_fill - FW'(1)));
        o_sts.out_free      = !r_out_valid || i_m_ready;
    end

    // Mode register, fill count and mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_fill <= '0;
            r_mask <= '0;
        end else begin
            if (i_cmd.mode_wr) r_mode <= i_cfg_data;
            if (i_cmd.blk_clr) begin
                r_fill <= '0;
                r_mask <= '0;
            end else if (i_cmd.byte_wr) begin
                r_fill <= w_fill_inc;
                r_mask <= n_mask;
            end
        end
    end

    // Block store
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) r_store[w_pos[CW-1:0]] <= w_byte_clr;
    end

    assign w_rd_byte = r_store[r_cnt];

    // Emit counter, shared by preamble and block readout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // Select the next output byte
    always_comb begin
        unique case (i_cmd.out_sel)
            SEL_PRE:  n_out_byte = PREAMBLE_BYTE;
            SEL_MASK: n_out_byte = {1'b0, r_mask};
            SEL_DATA: n_out_byte = w_rd_byte;
            default:  n_out_byte = PREAMBLE_BYTE;
        endcase
    end

    // Output register: hold while stalled, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_byte <= n_out_byte;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_byte  = r_out_byte;
    assign o_m_last  = r_out_last;

endmodule

FILE: src/lsb_mask_block_frame_encoder.sv
`timescale 1ns / 1ps

// Byte-stream frame encoder. Commands arrive on the slave stream with the kind in tuser
// (start, data byte, commit) and the byte in tdata; encoded bytes leave one per cycle on
// the master stream while the sink is ready, with tlast on the final byte caused by each
// transaction. A data byte that does not complete a block is only stored. A start sends
// the 3 preamble bytes; a completed block or a non-empty commit sends a mask byte and
// then the N stored bytes (N up to 7, or up to BLOCK_DATA_MAX in wide mode). The single
// output byte register holds each byte, and the input is not taken while a block or
// preamble is being sent. A mode write through the cfg channel drops any partial block.
// No clearing pass follows reset.
module lsb_mask_block_frame_encoder
    import lmbfe_pkg::*;
#(
    parameter int BLOCK_DATA_MAX = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0] i_s_axis_tuser,  // [1:0] cmd
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data       // wide_block_mode
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lmbfe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .i_s_cmd     (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (w_sts),
        .o_s_ready   (o_s_axis_tready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    lmbfe_dp #(
        .BLOCK_DATA_MAX (BLOCK_DATA_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_data     (i_s_axis_tdata),
        .i_cfg_data (i_cfg_data),
        .i_m_ready  (i_m_axis_tready),
        .o_sts      (w_sts),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_byte   (o_m_axis_tdata),
        .o_m_last   (o_m_axis_tlast)
    );

endmodule

FILE: src/lmbfe_checker.sv
`timescale 1ns / 1ps

`include "lsb_mask_block_frame_encoder_macros.svh"

module lmbfe_checker
    import lmbfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic [1:0] i_s_axis_tuser,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       i_cfg_data
);

    // A stalled output transaction holds its byte and flag
    `LMBFE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output changed while stalled")

    // A register write never lands in the same cycle as an input transaction
    `LMBFE_ASSERT_AT(a_cfg_excl, i_clk, i_rst_n, !(i_cfg_valid && o_cfg_ready && i_s_axis_tvalid && o_s_axis_tready), "config write collided with input")

    // A start keeps the input closed while the preamble goes out
    `LMBFE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == CMD_START), !o_s_axis_tready, "input open during preamble")

    // The input closes only after taking a transaction
    `LMBFE_ASSERT_AT(a_ready_fall, i_clk, i_rst_n, $fell(o_s_axis_tready) |-> $past(i_s_axis_tvalid && o_s_axis_tready), "input closed without a transaction")

endmodule

bind lsb_mask_block_frame_encoder lmbfe_checker u_lmbfe_checker (.*);
